FILE: rtl/core/ogds_pkg.sv
// types, constants and helper functions for the 2x2 occupancy grid downsampler
// no dependencies; imported by the top level only
package ogds_pkg;

  localparam int CELL_W = 8;
  localparam int CFG_W  = 12;

  typedef logic [1:0] cls_t;
  typedef logic signed [CELL_W-1:0] cell_t;

  // cell classes, ordered so that a plain max gives the merge priority
  localparam cls_t CLS_NONE = 2'd0;
  localparam cls_t CLS_UNK  = 2'd1;
  localparam cls_t CLS_FREE = 2'd2;
  localparam cls_t CLS_OCC  = 2'd3;

  localparam cell_t VAL_UNK  = -8'sd1;
  localparam cell_t VAL_FREE = 8'sd0;
  localparam cell_t VAL_OCC  = 8'sd100;

  function automatic cls_t ogds_classify(input cell_t v);
    cls_t r;
    if (v == VAL_OCC) r = CLS_OCC;
    else if (v == VAL_FREE) r = CLS_FREE;
    else if (v == VAL_UNK) r = CLS_UNK;
    else r = CLS_NONE;
    return r;
  endfunction

  function automatic cls_t ogds_merge(input cls_t a, input cls_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic cell_t ogds_value(input cls_t c);
    cell_t r;
    unique case (c)
      CLS_OCC:  r = VAL_OCC;
      CLS_FREE: r = VAL_FREE;
      default:  r = VAL_UNK;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/core/ogds_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module ogds_ram #(
  parameter int WIDTH  = 2,
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/occupancy_grid_2x2_priority_downsample_top.sv
// 2x2 priority downsampler for occupancy grids, top level
// depends on ogds_pkg and ogds_ram
//
// usage:
//   s_axis carries fine cells in raster order, one request per cell; tdata is
//   the signed cell value, tuser marks the first cell of a new map.
//   m_axis carries one coarse cell per 2x2 block; tdata is the coarse value
//   (-1, 0 or 100), tlast marks the last coarse cell of a coarse row.
//   cfg_wr_en / cfg_wr_data set the fine row width, clamped to 2..MAX_WIDTH;
//   write it only while the stream is idle.
// timing: one cell per cycle sustained unless m_axis stalls; a coarse cell is
//   presented in the cycle after the request carrying the lower right cell of
//   its block. merged upper row classes sit in a ram read when the lower left
//   cell arrives, so the right cell merges straight into the output register.
// reset: counters clear, output goes invalid, width returns to 2; the row
//   ram is not cleared and needs no clearing pass.
// stall: while a coarse cell waits on m_axis_tready, s_axis_tready drops; a
//   cell that produces no output still needs the output register free.
module occupancy_grid_2x2_priority_downsample_top
  import ogds_pkg::*;
#(
  parameter int MAX_WIDTH = 2048
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data,   // map_width
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [7:0]       s_axis_tdata,  // [7:0] cell_value
  input  logic [0:0]       s_axis_tuser,  // [0] start_of_map
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [7:0]       m_axis_tdata,  // [7:0] sub_value
  output logic             m_axis_tlast   // end_of_row
);

  localparam int DEPTH  = MAX_WIDTH / 2;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int WW     = ($clog2(MAX_WIDTH + 1) + 1 > CFG_W + 1) ?
                          $clog2(MAX_WIDTH + 1) + 1 : CFG_W + 1;

  logic [CFG_W-1:0] width_cfg;
  logic [COL_W-1:0] column_count, column_count_next;
  logic             odd_row, odd_row_next;
  cls_t             pair_class, pair_class_next;

  logic [WW-1:0]    w_eff, cfg_ext, c_ext, c_inc;
  logic [COL_W-1:0] c_cur;
  logic             odd_cur, is_even, row_end, accept;
  cls_t             pc_cur, cls, pair_merge, full_merge, upper_cls;
  logic             wr_en, rd_en, emit, eor;
  logic [ADDR_W-1:0] idx;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;

  always_comb begin
    cfg_ext = WW'(width_cfg);
    if (cfg_ext < WW'(2)) w_eff = WW'(2);
    else if (cfg_ext > WW'(MAX_WIDTH)) w_eff = WW'(MAX_WIDTH);
    else w_eff = cfg_ext;

    cls     = ogds_classify(cell_t'(s_axis_tdata));
    c_cur   = s_axis_tuser[0] ? '0 : column_count;
    odd_cur = s_axis_tuser[0] ? 1'b0 : odd_row;
    pc_cur  = s_axis_tuser[0] ? CLS_NONE : pair_class;

    c_ext   = WW'(c_cur);
    c_inc   = c_ext + WW'(1);
    is_even = !c_cur[0];
    row_end = (c_inc >= w_eff);
    idx     = ADDR_W'(c_cur >> 1);

    pair_merge = ogds_merge(pc_cur, cls);
    full_merge = ogds_merge(pair_merge, upper_cls);
    eor        = ((c_ext >> 1) == ((w_eff >> 1) - WW'(1)));

    wr_en = accept && !is_even && (c_ext < w_eff) && !odd_cur;
    rd_en = accept && is_even && (c_inc < w_eff) && odd_cur;
    emit  = accept && !is_even && (c_ext < w_eff) && odd_cur;

    pair_class_next   = (is_even && (c_inc < w_eff)) ? cls : pc_cur;
    column_count_next = row_end ? '0 : COL_W'(c_inc);
    odd_row_next      = row_end ? !odd_cur : odd_cur;
  end

  ogds_ram #(
    .WIDTH  (2),
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_upper_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (idx),
    .wdata (pair_merge),
    .re    (rd_en),
    .raddr (idx),
    .rdata (upper_cls)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      width_cfg     <= CFG_W'(2);
      column_count  <= '0;
      odd_row       <= 1'b0;
      pair_class    <= CLS_NONE;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        width_cfg <= cfg_wr_data;
      end
      if (accept) begin
        column_count <= column_count_next;
        odd_row      <= odd_row_next;
        pair_class   <= pair_class_next;
      end
      if (s_axis_tready) begin
        m_axis_tvalid <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_axis_tdata <= ogds_value(full_merge);
      m_axis_tlast <= eor;
    end
  end

endmodule

FILE: rtl/core/ogds_checker.sv
// port-level checker for the 2x2 occupancy grid downsampler, with its bind
// depends on the top level occupancy_grid_2x2_priority_downsample_top
module ogds_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast
);

  // stalled output request holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled output request changed");

  // coarse values are only unknown, free or occupied
  a_out_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |->
      (m_axis_tdata == 8'hFF) || (m_axis_tdata == 8'h00) || (m_axis_tdata == 8'd100))
    else $error("coarse value out of range");

  // a new output request follows an accepted input request
  a_out_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready))
    else $error("output request without input request");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  // empty output register never blocks the input
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input blocked with empty output");

endmodule

bind occupancy_grid_2x2_priority_downsample_top ogds_checker u_ogds_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
